### src/wpo_pkg.sv
// ----------------------------------------------------------------------------
// wpo_pkg
// Shared types, constants, constant tables and the microprogram of the Wnt
// pathway derivative core.
// ----------------------------------------------------------------------------
package wpo_pkg;

    localparam int WORD_WIDTH = 48;
    localparam int FRAC_BITS  = 24;
    localparam int NUM_VARS   = 17;
    localparam int IDX_W      = 5;
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(NUM_VARS - 1);
    localparam int RF_DEPTH   = 32;
    localparam int RF_AW      = 5;
    localparam int ADDR_W     = 3;
    localparam int CNT_W      = $clog2(WORD_WIDTH + FRAC_BITS + 1);

    // Register indexes on the configuration port.
    localparam logic REG_MUTATION   = 1'b0;
    localparam logic REG_HYPOTHESIS = 1'b1;

    // Mutation codes.
    localparam logic [2:0] MUT_APC_ONE  = 3'd2;
    localparam logic [2:0] MUT_APC_TWO  = 3'd3;
    localparam logic [2:0] MUT_BCAT_ONE = 3'd4;

    typedef logic signed [WORD_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t state_value;
        logic  last_variable;
    } in_item_t;

    typedef struct packed {
        word_t            derivative_value;
        logic [IDX_W-1:0] variable_index;
        logic             last_result;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_LD, OP_ST, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] src;
    } instr_t;

    typedef enum logic [1:0] {
        SEQ_LOAD, SEQ_FETCH, SEQ_WAIT, SEQ_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        AU_IDLE, AU_MUL, AU_DIV, AU_FIN
    } au_state_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } arith_req_t;

    typedef struct packed {
        logic done;
    } arith_rsp_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    // Operand sources: register file slots, then constants with the top bit set.
    localparam logic [5:0] R_D   = 6'd0,  R_X   = 6'd1,  R_CU  = 6'd2,  R_CO  = 6'd3;
    localparam logic [5:0] R_CC  = 6'd4,  R_MO  = 6'd5,  R_MC  = 6'd6,  R_A   = 6'd7;
    localparam logic [5:0] R_CA  = 6'd8,  R_MA  = 6'd9,  R_T   = 6'd10, R_COT = 6'd11;
    localparam logic [5:0] R_CCT = 6'd12, R_MOT = 6'd13, R_MCT = 6'd14, R_Y   = 6'd15;
    localparam logic [5:0] R_SW  = 6'd16;
    localparam logic [5:0] T_CF  = 6'd17, T_CT  = 6'd18, T_MF  = 6'd19, T_MT  = 6'd20;
    localparam logic [5:0] T_DD  = 6'd21, T_DXH = 6'd22, T_PCH = 6'd23, T_KC  = 6'd24;
    localparam logic [5:0] T_CFKD = 6'd25, T_TCF = 6'd26, T_TCFDC = 6'd27;
    localparam logic [5:0] T_TCAF = 6'd28, T_P100D = 6'd29, T_OMX = 6'd30, T_S = 6'd31;
    localparam logic [5:0] T_W1  = 6'd21, T_W2  = 6'd22;
    localparam logic [5:0] C_ZERO = 6'd32, C_K1 = 6'd33, C_K2 = 6'd34, C_K5 = 6'd35;
    localparam logic [5:0] C_K10 = 6'd36, C_K20 = 6'd37, C_K25 = 6'd38, C_K30 = 6'd39;
    localparam logic [5:0] C_K50 = 6'd40, C_K100 = 6'd41, C_K200 = 6'd42;
    localparam logic [5:0] C_K250 = 6'd43, C_K350 = 6'd44, C_K750 = 6'd45;
    localparam logic [5:0] C_OMSD = 6'd46, C_OMSB = 6'd47, C_SB = 6'd48;
    localparam logic [5:0] C_XIC = 6'd49, C_DT = 6'd50;

    // Integer rate constant in fixed point, saturated to the word.
    function automatic word_t kint(longint n);
        longint lim;
        lim = longint'(1) << (WORD_WIDTH - 1 - FRAC_BITS);
        if (n >= lim) begin
            return WORD_MAX;
        end
        return word_t'(n << FRAC_BITS);
    endfunction

    localparam word_t K_HALF = word_t'(longint'(1) << (FRAC_BITS - 1));
    localparam word_t K_ONE  = kint(1);
    localparam word_t K_DT   = word_t'(((longint'(4) << FRAC_BITS) + 5) / 10);

    function automatic word_t const_value(logic [5:0] src, logic [2:0] mut, logic hyp);
        word_t omsd;
        word_t sb;
        omsd = K_ONE;
        sb   = '0;
        if (mut == MUT_APC_ONE) begin
            omsd = K_HALF;
        end else if (mut == MUT_APC_TWO) begin
            omsd = '0;
        end else if (mut == MUT_BCAT_ONE) begin
            sb = K_HALF;
        end
        case (src)
            C_K1:    return K_ONE;
            C_K2:    return kint(2);
            C_K5:    return kint(5);
            C_K10:   return kint(10);
            C_K20:   return kint(20);
            C_K25:   return kint(25);
            C_K30:   return kint(30);
            C_K50:   return kint(50);
            C_K100:  return kint(100);
            C_K200:  return kint(200);
            C_K250:  return kint(250);
            C_K350:  return kint(350);
            C_K750:  return kint(750);
            C_OMSD:  return omsd;
            C_OMSB:  return K_ONE - sb;
            C_SB:    return sb;
            C_XIC:   return hyp ? kint(5000) : '0;
            C_DT:    return K_DT;
            default: return '0;
        endcase
    endfunction

    function automatic instr_t mk(op_t op, logic [5:0] src);
        instr_t i;
        i.op  = op;
        i.src = src;
        return i;
    endfunction

    localparam int PROG_LEN = 242;
    localparam int PC_W     = $clog2(PROG_LEN);

    // Accumulator microprogram: LD loads, ST stores, arithmetic ops combine the
    // accumulator with the operand, EMIT sends the accumulator as a result.
    localparam instr_t PROG [PROG_LEN] = '{
        // shared terms
        mk(OP_LD, R_CC),  mk(OP_ADD, R_CO),  mk(OP_ST, T_CF),
        mk(OP_LD, R_CCT), mk(OP_ADD, R_COT), mk(OP_ST, T_CT),
        mk(OP_LD, R_MC),  mk(OP_ADD, R_MO),  mk(OP_ST, T_MF),
        mk(OP_LD, R_MCT), mk(OP_ADD, R_MOT), mk(OP_ST, T_MT),
        mk(OP_LD, C_K5),  mk(OP_MUL, R_SW),  mk(OP_ADD, C_K5),  mk(OP_ST, T_DD),
        mk(OP_LD, C_K200), mk(OP_MUL, R_SW), mk(OP_ADD, C_K100), mk(OP_ST, T_DXH),
        mk(OP_LD, C_XIC), mk(OP_MUL, R_SW),  mk(OP_ST, T_PCH),
        mk(OP_LD, R_CO),  mk(OP_ADD, R_MO),  mk(OP_ADD, C_K200), mk(OP_ST, T_KC),
        mk(OP_LD, T_CF),  mk(OP_ADD, C_K5),  mk(OP_ST, T_CFKD),
        mk(OP_LD, C_K30), mk(OP_MUL, R_T),   mk(OP_ST, T_TCF),
        mk(OP_LD, T_TCF), mk(OP_ADD, C_K1),  mk(OP_ST, T_TCFDC),
        mk(OP_LD, C_K250), mk(OP_MUL, R_A),  mk(OP_ADD, T_TCF), mk(OP_ADD, C_K1),
        mk(OP_ST, T_TCAF),
        mk(OP_LD, C_K100), mk(OP_MUL, R_D),  mk(OP_ST, T_P100D),
        mk(OP_LD, C_OMSD), mk(OP_MUL, C_K100), mk(OP_MUL, R_X), mk(OP_ST, T_OMX),
        // D
        mk(OP_LD, T_DD),  mk(OP_ADD, T_DD),  mk(OP_MUL, R_D),   mk(OP_ST, T_S),
        mk(OP_LD, T_OMX), mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // X
        mk(OP_LD, T_DXH), mk(OP_MUL, R_X),   mk(OP_ST, T_S),    mk(OP_LD, C_K10),
        mk(OP_SUB, T_OMX), mk(OP_SUB, T_S),  mk(OP_ST, T_DXH),  mk(OP_LD, T_DD),
        mk(OP_MUL, R_D),  mk(OP_ADD, T_DXH), mk(OP_EMIT, C_ZERO),
        // Cu
        mk(OP_LD, C_K50), mk(OP_MUL, R_CU),  mk(OP_ST, T_S),    mk(OP_LD, T_P100D),
        mk(OP_MUL, T_CF), mk(OP_DIV, T_CFKD), mk(OP_SUB, T_S),  mk(OP_EMIT, C_ZERO),
        // Co
        mk(OP_LD, T_PCH), mk(OP_MUL, R_CO),  mk(OP_DIV, T_KC),  mk(OP_ST, T_W1),
        mk(OP_LD, C_K350), mk(OP_MUL, R_CA), mk(OP_ST, T_S),    mk(OP_LD, C_OMSB),
        mk(OP_MUL, C_K25), mk(OP_ADD, T_S),  mk(OP_ST, T_W2),
        mk(OP_LD, C_K750), mk(OP_MUL, R_COT), mk(OP_ADD, T_W2), mk(OP_ST, T_W2),
        mk(OP_LD, T_TCAF), mk(OP_MUL, R_CO), mk(OP_ST, T_S),    mk(OP_LD, T_W2),
        mk(OP_SUB, T_S),  mk(OP_SUB, T_W1),  mk(OP_ST, T_W2),
        mk(OP_LD, T_P100D), mk(OP_MUL, R_CO), mk(OP_DIV, T_CFKD), mk(OP_ST, T_S),
        mk(OP_LD, T_W2),  mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // Cc
        mk(OP_LD, C_K750), mk(OP_MUL, R_CCT), mk(OP_ADD, T_W1), mk(OP_ST, T_W2),
        mk(OP_LD, T_TCFDC), mk(OP_MUL, R_CC), mk(OP_ST, T_S),   mk(OP_LD, T_W2),
        mk(OP_SUB, T_S),  mk(OP_ST, T_W2),
        mk(OP_LD, T_P100D), mk(OP_MUL, R_CC), mk(OP_DIV, T_CFKD), mk(OP_ST, T_S),
        mk(OP_LD, T_W2),  mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // Mo
        mk(OP_LD, T_PCH), mk(OP_MUL, R_MO),  mk(OP_DIV, T_KC),  mk(OP_ST, T_W1),
        mk(OP_LD, C_K350), mk(OP_MUL, R_MA), mk(OP_ST, T_S),    mk(OP_LD, C_SB),
        mk(OP_MUL, C_K25), mk(OP_ADD, T_S),  mk(OP_ST, T_W2),
        mk(OP_LD, C_K750), mk(OP_MUL, R_MOT), mk(OP_ADD, T_W2), mk(OP_ST, T_W2),
        mk(OP_LD, T_TCAF), mk(OP_MUL, R_MO), mk(OP_ST, T_S),    mk(OP_LD, T_W2),
        mk(OP_SUB, T_S),  mk(OP_SUB, T_W1),  mk(OP_EMIT, C_ZERO),
        // Mc
        mk(OP_LD, T_TCFDC), mk(OP_MUL, R_MC), mk(OP_ST, T_S),   mk(OP_LD, C_K750),
        mk(OP_MUL, R_MCT), mk(OP_ADD, T_W1), mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // A
        mk(OP_LD, R_CO),  mk(OP_ADD, R_MO),  mk(OP_MUL, C_K250), mk(OP_ADD, C_K2),
        mk(OP_MUL, R_A),  mk(OP_ST, T_S),    mk(OP_LD, R_CA),   mk(OP_ADD, R_MA),
        mk(OP_MUL, C_K350), mk(OP_ADD, C_K20), mk(OP_SUB, T_S), mk(OP_EMIT, C_ZERO),
        // Ca
        mk(OP_LD, C_K350), mk(OP_MUL, R_CA), mk(OP_ST, T_S),    mk(OP_LD, C_K250),
        mk(OP_MUL, R_CO), mk(OP_MUL, R_A),   mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // Ma
        mk(OP_LD, C_K350), mk(OP_MUL, R_MA), mk(OP_ST, T_S),    mk(OP_LD, C_K250),
        mk(OP_MUL, R_MO), mk(OP_MUL, R_A),   mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // T
        mk(OP_LD, T_CF),  mk(OP_ADD, T_MF),  mk(OP_MUL, C_K30), mk(OP_MUL, R_T),
        mk(OP_ST, T_S),   mk(OP_LD, C_DT),   mk(OP_MUL, R_T),   mk(OP_ST, T_W1),
        mk(OP_LD, T_CT),  mk(OP_ADD, T_MT),  mk(OP_MUL, C_K750), mk(OP_ADD, C_K10),
        mk(OP_SUB, T_S),  mk(OP_SUB, T_W1),  mk(OP_EMIT, C_ZERO),
        // Cot
        mk(OP_LD, C_K750), mk(OP_MUL, R_COT), mk(OP_ST, T_S),   mk(OP_LD, C_K30),
        mk(OP_MUL, R_CO), mk(OP_MUL, R_T),   mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // Cct
        mk(OP_LD, C_K750), mk(OP_MUL, R_CCT), mk(OP_ST, T_S),   mk(OP_LD, C_K30),
        mk(OP_MUL, R_CC), mk(OP_MUL, R_T),   mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // Mot
        mk(OP_LD, C_K750), mk(OP_MUL, R_MOT), mk(OP_ST, T_S),   mk(OP_LD, C_K30),
        mk(OP_MUL, R_MO), mk(OP_MUL, R_T),   mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // Mct
        mk(OP_LD, C_K750), mk(OP_MUL, R_MCT), mk(OP_ST, T_S),   mk(OP_LD, C_K30),
        mk(OP_MUL, R_MC), mk(OP_MUL, R_T),   mk(OP_SUB, T_S),   mk(OP_EMIT, C_ZERO),
        // Y
        mk(OP_LD, T_CT),  mk(OP_ADD, T_MT),  mk(OP_ST, T_W1),   mk(OP_ADD, C_K50),
        mk(OP_ST, T_W2),  mk(OP_LD, T_W1),   mk(OP_MUL, C_K10), mk(OP_DIV, T_W2),
        mk(OP_ST, T_S),   mk(OP_LD, C_K1),   mk(OP_MUL, R_Y),   mk(OP_ST, T_W1),
        mk(OP_LD, T_S),   mk(OP_SUB, T_W1),  mk(OP_EMIT, C_ZERO),
        // stimulus
        mk(OP_LD, C_ZERO), mk(OP_EMIT, C_ZERO)
    };

endpackage

### src/wnt_pathway_ode_rhs_core.sv
// ----------------------------------------------------------------------------
// wnt_pathway_ode_rhs_core
// Right-hand side of the Wnt pathway ODE for one cell, in saturating fixed point.
// ----------------------------------------------------------------------------
// The core takes the 17 concentrations of one cell's state, one transfer each,
// in variable order; the seventeenth (or any transfer marked last_variable) is
// the Wnt stimulus and starts evaluation with the slots as they stand.
// Evaluation runs a fixed microprogram of 242 steps on one shared arithmetic
// unit: a load step fills the accumulator, a store step writes it to the
// register file, a result step waits for the result side to be ready, and
// add, subtract, multiply and divide go to the arithmetic unit, the multiply
// and divide through bit-serial loops (a zero divisor skips the divide loop).
// The program holds 56 multiplies and 6 divides. The 17 derivatives leave in
// index order; the input side is not ready from the stimulus until the last
// derivative has been transferred. Configuration (mutation_state at byte 0,
// hypothesis_two at byte 4) is to be written over the APB port only while the
// core is idle; the core has no check for this, and it has no clearing pass.
module wnt_pathway_ode_rhs_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  wpo_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output wpo_pkg::out_item_t           m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wpo_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import wpo_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [IDX_W-1:0]  load_count_reg, load_count_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    word_t             acc_reg, acc_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;
    logic [2:0]        mutation_reg;
    logic              hyp_reg;
    word_t             rf_reg [RF_DEPTH];

    logic              rf_we;
    logic [RF_AW-1:0]  rf_waddr;
    word_t             rf_wdata;
    instr_t            instr;
    word_t             operand;
    arith_req_t        au_req;
    arith_rsp_t        au_rsp;
    word_t             au_result;
    logic              s_take;

    // Configuration port: writes land on the access phase, reads are direct.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HYPOTHESIS) ? {31'd0, hyp_reg} : {29'd0, mutation_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mutation_reg <= '0;
            hyp_reg      <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MUTATION) begin
                mutation_reg <= pwdata[2:0];
            end else begin
                hyp_reg <= pwdata[0];
            end
        end
    end

    // The current step reads its operand either from a constant or from the
    // register file, which holds the loaded state and the scratch terms.
    assign instr   = PROG[pc_reg];
    assign operand = instr.src[5] ? const_value(instr.src, mutation_reg, hyp_reg)
                                  : rf_reg[instr.src[RF_AW-1:0]];
    assign s_take  = s_valid && s_ready;
    assign s_ready = (state_reg == SEQ_LOAD);

    always_comb begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        load_count_next = load_count_reg;
        out_idx_next    = out_idx_reg;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        rf_we           = 1'b0;
        rf_waddr        = instr.src[RF_AW-1:0];
        rf_wdata        = acc_reg;
        au_req.start    = 1'b0;
        au_req.op       = instr.op;
        unique case (state_reg)
            SEQ_LOAD: begin
                if (s_take) begin
                    rf_we    = 1'b1;
                    rf_wdata = s_data.state_value;
                    // A marked transfer, or the seventeenth, is the stimulus.
                    if (s_data.last_variable || load_count_reg == LAST_INDEX) begin
                        rf_waddr        = RF_AW'(LAST_INDEX);
                        load_count_next = '0;
                        pc_next         = '0;
                        out_idx_next    = '0;
                        state_next      = SEQ_FETCH;
                    end else begin
                        rf_waddr        = RF_AW'(load_count_reg);
                        load_count_next = load_count_reg + 1'b1;
                    end
                end
            end
            SEQ_FETCH: begin
                unique case (instr.op)
                    OP_LD: begin
                        acc_next = operand;
                        pc_next  = pc_reg + 1'b1;
                    end
                    OP_ST: begin
                        rf_we   = 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                    OP_EMIT: begin
                        m_valid_next                 = 1'b1;
                        m_data_next.derivative_value = acc_reg;
                        m_data_next.variable_index   = out_idx_reg;
                        m_data_next.last_result      = (out_idx_reg == LAST_INDEX);
                        state_next                   = SEQ_EMIT;
                    end
                    default: begin
                        au_req.start = 1'b1;
                        state_next   = SEQ_WAIT;
                    end
                endcase
            end
            SEQ_WAIT: begin
                if (au_rsp.done) begin
                    acc_next   = au_result;
                    pc_next    = pc_reg + 1'b1;
                    state_next = SEQ_FETCH;
                end
            end
            SEQ_EMIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (out_idx_reg == LAST_INDEX) begin
                        pc_next    = '0;
                        state_next = SEQ_LOAD;
                    end else begin
                        out_idx_next = out_idx_reg + 1'b1;
                        pc_next      = pc_reg + 1'b1;
                        state_next   = SEQ_FETCH;
                    end
                end
            end
            default: state_next = SEQ_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_LOAD;
            pc_reg         <= '0;
            load_count_reg <= '0;
            out_idx_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            load_count_reg <= load_count_next;
            out_idx_reg    <= out_idx_next;
            m_valid_reg    <= m_valid_next;
        end
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
        if (rf_we) begin
            rf_reg[rf_waddr] <= rf_wdata;
        end
    end

    wpo_arith_unit u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (au_req),
        .a       (acc_reg),
        .b       (operand),
        .rsp     (au_rsp),
        .result  (au_result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/wpo_arith_unit.sv
// ----------------------------------------------------------------------------
// wpo_arith_unit
// Shared saturating fixed-point unit: registered add and subtract, a
// shift-add multiplier one bit a cycle and a restoring divider one bit a cycle.
// ----------------------------------------------------------------------------
module wpo_arith_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  wpo_pkg::arith_req_t req,
    input  wpo_pkg::word_t     a,
    input  wpo_pkg::word_t     b,
    output wpo_pkg::arith_rsp_t rsp,
    output wpo_pkg::word_t     result
);
    import wpo_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = 2 * W;

    au_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]      hi_reg, hi_next, lo_reg, lo_next;
    logic [W-1:0]      ma_reg, ma_next, mb_reg, mb_next;
    logic [W:0]        rem_reg, rem_next;
    logic [W+F-1:0]    num_reg, num_next, quo_reg, quo_next;
    logic              neg_reg, neg_next, mul_reg, mul_next;
    logic              done_reg, done_next;
    word_t             res_reg, res_next;

    logic [W:0]        sum;
    logic [W:0]        psum;
    logic [W:0]        rs;
    logic [QW-1:0]     qfull, lim, msat;
    logic [W-1:0]      mag_a, mag_b;

    always_comb begin
        mag_a = a[W-1] ? W'(-a) : W'(a);
        mag_b = b[W-1] ? W'(-b) : W'(b);
        if (req.op == OP_SUB) begin
            sum = {a[W-1], a} - {b[W-1], b};
        end else begin
            sum = {a[W-1], a} + {b[W-1], b};
        end
        psum  = {1'b0, hi_reg} + (mb_reg[0] ? {1'b0, ma_reg} : '0);
        rs    = {rem_reg[W-1:0], num_reg[W+F-1]};
        qfull = mul_reg ? ({hi_reg, lo_reg} >> F) : QW'(quo_reg);
        lim   = (QW'(1) << (W - 1)) - (neg_reg ? QW'(0) : QW'(1));
        msat  = (qfull > lim) ? lim : qfull;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        mul_next   = mul_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            AU_IDLE: begin
                if (req.start) begin
                    neg_next = a[W-1] ^ b[W-1];
                    ma_next  = mag_a;
                    mb_next  = mag_b;
                    hi_next  = '0;
                    lo_next  = '0;
                    rem_next = '0;
                    quo_next = '0;
                    num_next = {mag_a, {F{1'b0}}};
                    priority case (req.op)
                        OP_MUL: begin
                            mul_next   = 1'b1;
                            cnt_next   = CNT_W'(W - 1);
                            state_next = AU_MUL;
                        end
                        OP_DIV: begin
                            mul_next = 1'b0;
                            cnt_next = CNT_W'(W + F - 1);
                            if (b == '0) begin
                                // A nonzero over zero saturates by its sign; 0/0 gives zero.
                                if (a == '0) begin
                                    res_next = '0;
                                end else begin
                                    res_next = a[W-1] ? WORD_MIN : WORD_MAX;
                                end
                                done_next = 1'b1;
                            end else begin
                                state_next = AU_DIV;
                            end
                        end
                        default: begin
                            if (sum[W] != sum[W-1]) begin
                                res_next = sum[W] ? WORD_MIN : WORD_MAX;
                            end else begin
                                res_next = word_t'(sum[W-1:0]);
                            end
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            AU_MUL: begin
                hi_next = psum[W:1];
                lo_next = {psum[0], lo_reg[W-1:1]};
                mb_next = mb_reg >> 1;
                if (cnt_reg == '0) begin
                    state_next = AU_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            AU_DIV: begin
                if (rs >= {1'b0, mb_reg}) begin
                    rem_next = rs - {1'b0, mb_reg};
                    quo_next = {quo_reg[W+F-2:0], 1'b1};
                end else begin
                    rem_next = rs;
                    quo_next = {quo_reg[W+F-2:0], 1'b0};
                end
                num_next = num_reg << 1;
                if (cnt_reg == '0) begin
                    state_next = AU_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            AU_FIN: begin
                res_next   = neg_reg ? word_t'(-msat[W-1:0]) : word_t'(msat[W-1:0]);
                done_next  = 1'b1;
                state_next = AU_IDLE;
            end
            default: state_next = AU_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        mul_reg <= mul_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule

### src/wpo_checker.sv
// ----------------------------------------------------------------------------
// wpo_checker
// Port-level checks of the Wnt pathway derivative core, bound to the top level.
// ----------------------------------------------------------------------------
module wpo_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input wpo_pkg::in_item_t          s_data,
    input logic                       m_valid,
    input logic                       m_ready,
    input wpo_pkg::out_item_t         m_data
);
    import wpo_pkg::*;

    // The core never takes a new value while a derivative is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The last flag marks exactly the stimulus derivative.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_result == (m_data.variable_index == LAST_INDEX)))
        else $error("last flag does not match index");

    // A transferred non-final result is followed by the next index.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_result |=>
            !m_valid || (m_data.variable_index == $past(m_data.variable_index) + 1'b1))
        else $error("result index out of order");

endmodule

bind wnt_pathway_ode_rhs_core wpo_checker u_wpo_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wnt pathway derivative core testbench
// Streams concentration vectors into the core, predicts the 17 derivatives of
// each vector in saturating fixed point, and checks every result transfer
// field by field. The mutation and hypothesis registers are swept between
// phases over the configuration port.
// ----------------------------------------------------------------------------
module testbench;
    import wpo_pkg::*;

    // Fixed-point limits of the 48-bit word, held in 64-bit integers.
    localparam longint W_MAX = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
    localparam longint W_MIN = -W_MAX - 1;
    localparam logic [2:0] MUT_HEALTHY = 3'd0;
    localparam logic [2:0] MUT_HIGHEST = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 100;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    wnt_pathway_ode_rhs_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state: our own copy of the concentration slots, the load
    // position and the two configuration registers.
    longint conc_slot [NUM_VARS];
    int unsigned load_pos = 0;
    logic [2:0] mut_cfg = MUT_HEALTHY;
    logic hyp_cfg = 1'b0;

    out_item_t deriv_q[$];          // derivatives still owed by the core
    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned vectors_done = 0;
    int unsigned derivs_seen = 0;
    bit calm = 1'b0;                // when set, neither side idles

    // ------------------------------------------------------------------
    // Saturating fixed-point arithmetic at the core's word width.
    // ------------------------------------------------------------------
    function automatic longint wsat(longint x);
        if (x > W_MAX) return W_MAX;
        if (x < W_MIN) return W_MIN;
        return x;
    endfunction

    function automatic longint wadd(longint a, longint b);
        return wsat(a + b);
    endfunction

    function automatic longint wsub(longint a, longint b);
        return wsat(a - b);
    endfunction

    // Applies the sign to a magnitude; anything beyond the word saturates.
    function automatic longint signed_mag(bit neg, logic [127:0] m);
        longint r;
        if (m > (128'(1) << WORD_WIDTH)) m = 128'(1) << WORD_WIDTH;
        r = longint'(m[63:0]);
        return wsat(neg ? -r : r);
    endfunction

    // Multiply and divide truncate toward zero, so both work on magnitudes.
    function automatic longint wmul(longint a, longint b);
        logic [127:0] ma, mb;
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        return signed_mag((a < 0) != (b < 0), (ma * mb) >> FRAC_BITS);
    endfunction

    function automatic longint wdiv(longint a, longint b);
        logic [127:0] ma, mb;
        if (b == 0) begin
            if (a > 0) return W_MAX;
            if (a < 0) return W_MIN;
            return 0;
        end
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        return signed_mag((a < 0) != (b < 0), (ma << FRAC_BITS) / mb);
    endfunction

    function automatic longint kf(longint n);
        return n <<< FRAC_BITS;
    endfunction

    // Loads one concentration; on the stimulus, queues the 17 derivatives.
    function automatic void predict_derivs(longint v, logic mark);
        longint dy [NUM_VARS];
        longint omsd, sb, omsb, xic, half, dt;
        longint D, X, Cu, Co, Cc, Mo, Mc, A, Ca, Ma, T, Cot, Cct, Mot, Mct, Y, sw;
        longint cf, ct, mf, mt, ddh, dxh, pch, kcden, cfkd, tcf, tcfdc, tcaf;
        out_item_t r;
        if (!mark && load_pos < NUM_VARS - 1) begin
            conc_slot[load_pos] = v;
            load_pos++;
            return;
        end
        conc_slot[NUM_VARS - 1] = v;
        load_pos = 0;

        half = longint'(1) <<< (FRAC_BITS - 1);
        dt = ((longint'(4) <<< FRAC_BITS) + 5) / 10;
        omsd = kf(1);
        sb = 0;
        if (mut_cfg == MUT_APC_ONE) omsd = half;
        else if (mut_cfg == MUT_APC_TWO) omsd = 0;
        else if (mut_cfg == MUT_BCAT_ONE) sb = half;
        omsb = wsub(kf(1), sb);
        xic = hyp_cfg ? kf(5000) : 0;

        D = conc_slot[0];   X = conc_slot[1];    Cu = conc_slot[2];
        Co = conc_slot[3];  Cc = conc_slot[4];   Mo = conc_slot[5];
        Mc = conc_slot[6];  A = conc_slot[7];    Ca = conc_slot[8];
        Ma = conc_slot[9];  T = conc_slot[10];   Cot = conc_slot[11];
        Cct = conc_slot[12]; Mot = conc_slot[13]; Mct = conc_slot[14];
        Y = conc_slot[15];  sw = conc_slot[16];

        cf = wadd(Cc, Co);
        ct = wadd(Cct, Cot);
        mf = wadd(Mc, Mo);
        mt = wadd(Mct, Mot);
        ddh = wadd(kf(5), wmul(kf(5), sw));
        dxh = wadd(kf(100), wmul(kf(200), sw));
        pch = wmul(xic, sw);
        kcden = wadd(wadd(Co, Mo), kf(200));
        cfkd = wadd(cf, kf(5));
        tcf = wmul(kf(30), T);
        tcfdc = wadd(tcf, kf(1));
        tcaf = wadd(wadd(wmul(kf(250), A), tcf), kf(1));

        dy[0] = wsub(wmul(wmul(omsd, kf(100)), X), wmul(wadd(ddh, ddh), D));
        dy[1] = wadd(wsub(wsub(kf(10), wmul(wmul(omsd, kf(100)), X)), wmul(dxh, X)),
                     wmul(ddh, D));
        dy[2] = wsub(wdiv(wmul(wmul(kf(100), D), cf), cfkd), wmul(kf(50), Cu));
        dy[3] = wsub(wsub(wsub(wadd(wadd(wmul(omsb, kf(25)), wmul(kf(350), Ca)),
                                    wmul(kf(750), Cot)), wmul(tcaf, Co)),
                          wdiv(wmul(pch, Co), kcden)),
                     wdiv(wmul(wmul(kf(100), D), Co), cfkd));
        dy[4] = wsub(wsub(wadd(wdiv(wmul(pch, Co), kcden), wmul(kf(750), Cct)),
                          wmul(tcfdc, Cc)),
                     wdiv(wmul(wmul(kf(100), D), Cc), cfkd));
        dy[5] = wsub(wsub(wadd(wadd(wmul(sb, kf(25)), wmul(kf(350), Ma)),
                               wmul(kf(750), Mot)), wmul(tcaf, Mo)),
                     wdiv(wmul(pch, Mo), kcden));
        dy[6] = wsub(wadd(wdiv(wmul(pch, Mo), kcden), wmul(kf(750), Mct)),
                     wmul(tcfdc, Mc));
        dy[7] = wsub(wadd(kf(20), wmul(kf(350), wadd(Ca, Ma))),
                     wmul(wadd(wmul(kf(250), wadd(Co, Mo)), kf(2)), A));
        dy[8] = wsub(wmul(wmul(kf(250), Co), A), wmul(kf(350), Ca));
        dy[9] = wsub(wmul(wmul(kf(250), Mo), A), wmul(kf(350), Ma));
        dy[10] = wsub(wsub(wadd(kf(10), wmul(kf(750), wadd(ct, mt))),
                           wmul(wmul(kf(30), wadd(cf, mf)), T)), wmul(dt, T));
        dy[11] = wsub(wmul(wmul(kf(30), Co), T), wmul(kf(750), Cot));
        dy[12] = wsub(wmul(wmul(kf(30), Cc), T), wmul(kf(750), Cct));
        dy[13] = wsub(wmul(wmul(kf(30), Mo), T), wmul(kf(750), Mot));
        dy[14] = wsub(wmul(wmul(kf(30), Mc), T), wmul(kf(750), Mct));
        dy[15] = wsub(wdiv(wmul(kf(10), wadd(ct, mt)), wadd(wadd(ct, mt), kf(50))),
                      wmul(kf(1), Y));
        dy[16] = 0;

        for (int k = 0; k < NUM_VARS; k++) begin
            r.derivative_value = word_t'(dy[k]);
            r.variable_index = IDX_W'(k);
            r.last_result = (k == NUM_VARS - 1);
            deriv_q = {deriv_q, r};
        end
        vectors_done++;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts on m_ready, and the checker.
    // ------------------------------------------------------------------
    int unsigned ready_left = 0;
    always @(posedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            m_ready <= calm ? 1'b1 : 1'($urandom_range(0, 1));
            ready_left <= $urandom_range(1, 16);
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            derivs_seen++;
            if (deriv_q.size() == 0) begin
                errors++;
                $display("%0t: derivative transfer with nothing expected: %h", $time, m_data);
            end else begin
                want = deriv_q.pop_front();
                if (m_data.derivative_value !== want.derivative_value) begin
                    errors++;
                    $display("%0t: derivative_value idx %0d expected %0d actual %0d", $time,
                             want.variable_index, want.derivative_value,
                             m_data.derivative_value);
                end
                if (m_data.variable_index !== want.variable_index) begin
                    errors++;
                    $display("%0t: variable_index expected %0d actual %0d", $time,
                             want.variable_index, m_data.variable_index);
                end
                if (m_data.last_result !== want.last_result) begin
                    errors++;
                    $display("%0t: last_result expected %0b actual %0b", $time,
                             want.last_result, m_data.last_result);
                end
            end
        end
    end

    // Watchdog: ends the run if nothing moves on any port for too long.
    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d derivatives outstanding", $time,
                     deriv_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks.
    // ------------------------------------------------------------------
    // One concentration transfer; an idle burst may precede it.
    task automatic send_conc(longint v, logic mark);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.state_value <= word_t'(v);
        s_data.last_variable <= mark;
        do @(posedge aclk); while (!s_ready);
        predict_derivs(v, mark);
        items_sent++;
    endtask

    // Holds the sender until every owed derivative has been transferred.
    task automatic drain_core();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (deriv_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic apb_write(logic reg_sel, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_MUTATION) mut_cfg = value[2:0];
        else hyp_cfg = value[0];
    endtask

    task automatic apb_check(logic reg_sel, logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            errors++;
            $display("%0t: register %0d readback expected %h actual %h", $time,
                     reg_sel, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [2:0] mut, logic hyp);
        apb_write(REG_MUTATION, 32'(mut));
        apb_write(REG_HYPOTHESIS, 32'(hyp));
        apb_check(REG_MUTATION, 32'(mut));
        apb_check(REG_HYPOTHESIS, 32'(hyp));
    endtask

    // Mostly modest concentrations so the arithmetic stays in range, with
    // full-width noise and the word extremes mixed in.
    function automatic longint rand_conc();
        logic [WORD_WIDTH-1:0] raw;
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 2) == 0) ? W_MAX :
                      ($urandom_range(0, 1) == 0) ? W_MIN : 0;
            1, 2: begin
                raw = WORD_WIDTH'({$urandom, $urandom});
                return longint'(word_t'(raw));
            end
            default: return longint'($urandom_range(0, 1 << 28)) - (longint'(1) << 27);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_register_defaults();
        apb_check(REG_MUTATION, 32'(MUT_HEALTHY));
        apb_check(REG_HYPOTHESIS, 32'd0);
    endtask

    // One complete vector arranged so that every divisor in the system is
    // zero, then an early stimulus mark, then a stimulus on its own.
    task automatic test_directed();
        longint vec [NUM_VARS];
        set_config(MUT_APC_ONE, 1'b1);
        vec = '{kf(1), kf(2), W_MAX, -kf(5), 0, -kf(195), W_MIN, kf(1) >>> 1,
                kf(3), -kf(3), kf(1), 0, -kf(50), 0, 0, W_MIN, kf(2)};
        for (int i = 0; i < NUM_VARS; i++) send_conc(vec[i], i == NUM_VARS - 1);
        send_conc(W_MAX, 1'b0);
        send_conc(W_MIN, 1'b0);
        send_conc(0, 1'b0);
        send_conc(W_MAX, 1'b1);
        send_conc(W_MIN, 1'b1);
        drain_core();
    endtask

    // Every mutation code, unused ones included, with the hypothesis bit set to the code's low bit.
    task automatic test_config_sweep();
        for (int m = MUT_HEALTHY; m <= MUT_HIGHEST; m++) begin
            set_config(3'(m), 1'(m));
            for (int i = 0; i < NUM_VARS; i++) send_conc(rand_conc(), i == NUM_VARS - 1);
            drain_core();
        end
    endtask

    // Mostly well-formed vectors, some with the mark missing and some cut
    // short by an early mark. The last part runs without idling.
    task automatic test_random_vectors();
        int unsigned start_items, len, kind;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (items_sent - start_items > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
            kind = $urandom_range(0, 9);
            len = (kind == 9) ? $urandom_range(1, NUM_VARS - 1) : NUM_VARS;
            for (int i = 0; i < len; i++) begin
                send_conc(rand_conc(), (i == len - 1) && (kind != 8));
            end
            if ($urandom_range(0, 3) == 0) begin
                drain_core();
                set_config(3'($urandom_range(MUT_HEALTHY, MUT_HIGHEST)), 1'($urandom));
            end
        end
        drain_core();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_defaults();
        test_directed();
        test_config_sweep();
        test_random_vectors();
        $display("Sent %0d concentrations forming %0d vectors; checked %0d derivatives",
                 items_sent, vectors_done, derivs_seen);
        $display("across all eight mutation codes with both closing-gain settings.");
        if (errors == 0 && deriv_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
src/wpo_pkg.sv
src/wpo_arith_unit.sv
src/wnt_pathway_ode_rhs_core.sv
src/wpo_checker.sv
tb/testbench.sv
